// ----- rtl/cross_entropy_loss_scorer_macros.svh -----
// ----------------------------------------------------------------------------
// cross_entropy_loss_scorer macros
// assertion helpers, empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef CROSS_ENTROPY_LOSS_SCORER_MACROS_SVH
`define CROSS_ENTROPY_LOSS_SCORER_MACROS_SVH

`ifndef SYNTHESIS
`define CEL_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cel assertion failed");
`define CEL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cel assertion failed");
`else
`define CEL_ASSERT(lbl, cond)
`define CEL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/cel_pkg.sv -----
// ----------------------------------------------------------------------------
// cel_pkg
// types, constants and the log table builder for the cross entropy scorer
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int MAX_CLASSES     = 16;
  localparam int LOG_TABLE_DEPTH = 256;
  localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);
  localparam int IDX_W           = $clog2(MAX_CLASSES);
  localparam int CLS_W           = 5;
  localparam int Q_W             = 17;
  localparam int NUM_W           = 34;
  localparam int DVD_W           = NUM_W + 1;
  localparam int DIV_STEPS       = DVD_W;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);
  localparam int NLOG_W          = 20;
  localparam int TERM_W          = 22;
  localparam int ROM_W           = 16;
  localparam int GRAD_W          = 41;
  localparam int LOSS_W          = 24;
  localparam int CNT_W           = 32;
  localparam int CUM_W           = 48;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = 1;
  localparam int QCNT_W          = 2;

  localparam logic [NLOG_W-1:0] LN2_Q16      = NLOG_W'(45426);
  localparam logic [GRAD_W-1:0] GRAD_MAG_MAX = GRAD_W'(64'h100_0000_0000);
  localparam logic [Q_W-1:0]    ONE_Q16      = Q_W'(65536);

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic CFG_CLASS_COUNT   = 1'b0;
  localparam logic CFG_INVERSE_BATCH = 1'b1;

  typedef struct packed {
    logic           operation;
    logic [Q_W-1:0] probability;
    logic [Q_W-1:0] target;
  } item_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic                     sample_done;
    logic [LOSS_W-1:0]        sample_loss;
    logic                     hit;
    logic [CNT_W-1:0]         correct_total;
    logic [CNT_W-1:0]         incorrect_total;
    logic [CUM_W-1:0]         loss_total;
  } result_t;

  typedef struct packed {
    logic              operation;
    logic [Q_W-1:0]    probability;
    logic              target_nz;
    logic [NUM_W-1:0]  num;
    logic [TERM_W-1:0] term;
  } entry_t;

  typedef enum logic [1:0] {F_IDLE, F_LOG, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_FIN} back_state_t;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[63:0], a[j]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/depth) in q.16 via 2*atanh series
  function automatic logic [LOG_TABLE_DEPTH*ROM_W-1:0] build_log_rom();
    logic [LOG_TABLE_DEPTH*ROM_W-1:0] rom;
    logic [63:0] y;
    logic [63:0] yy;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] ent;
    rom = '0;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      y = udiv64(64'(i) << 30, 64'(2 * LOG_TABLE_DEPTH + i));
      yy = (y * y) >> 30;
      term = y;
      sum = '0;
      for (int k = 1; k < 120; k += 2) begin
        if (term != 0) begin
          sum = sum + udiv64(term, 64'(k));
          term = (term * yy) >> 30;
        end
      end
      ent = (2 * sum + 64'(1 << 13)) >> 14;
      rom[i*ROM_W +: ROM_W] = ent[ROM_W-1:0];
    end
    return rom;
  endfunction

endpackage

// ----- rtl/cross_entropy_loss_scorer.sv -----
// ----------------------------------------------------------------------------
// cross_entropy_loss_scorer
// fused categorical cross-entropy loss, gradient and accuracy scorer
// ----------------------------------------------------------------------------
// usage: one word on the item channel per class element (or a clear of the
// totals); one word leaves on the result channel for each item, in order.
// item_valid/item_ready and result_valid/result_ready are valid/ready pairs.
// configuration goes through cfg_we, cfg_index and cfg_data while idle:
// index 0 is class_count, index 1 is inverse_batch.
// the front takes a word, looks up -ln(p) and forms t*-ln(p) and
// inverse_batch*t through its idle, log and push states, then hands it
// over a two-entry queue. the back runs a one-bit-per-cycle divider for
// the gradient and a final state to update the sample state and totals.
// the back finishes one item before it pops the next, and a clear skips
// the divider. the front takes the next word while the back divides.
// reset (rst, synchronous) empties the queue, zeroes all sample state and
// totals and restores class_count 16 and inverse_batch 1.0.
// when result_ready stays low the finished word is held, the back waits
// before its commit, and the queue and then item_ready fill and stall.
// ----------------------------------------------------------------------------
module cross_entropy_loss_scorer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  cel_pkg::item_t          item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output cel_pkg::result_t        result,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [cel_pkg::Q_W-1:0] cfg_data
);

  logic [cel_pkg::CLS_W-1:0] class_count;
  logic [cel_pkg::Q_W-1:0]   inverse_batch;

  logic            push;
  logic            full;
  logic            pop;
  logic            pop_valid;
  cel_pkg::entry_t push_data;
  cel_pkg::entry_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count   <= cel_pkg::CLS_W'(cel_pkg::MAX_CLASSES);
      inverse_batch <= cel_pkg::ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        cel_pkg::CFG_CLASS_COUNT:   class_count   <= cfg_data[cel_pkg::CLS_W-1:0];
        cel_pkg::CFG_INVERSE_BATCH: inverse_batch <= cfg_data;
        default: ;
      endcase
    end
  end

  cel_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .inverse_batch (inverse_batch),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  cel_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  cel_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_data     (pop_data),
    .pop          (pop),
    .class_count  (class_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- rtl/cel_front.sv -----
// ----------------------------------------------------------------------------
// cel_front
// takes input words, looks up -ln(p) and forms the loss term and divide numerator
// ----------------------------------------------------------------------------
module cel_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  cel_pkg::item_t            item,
  input  logic [cel_pkg::Q_W-1:0]   inverse_batch,
  output logic                      push,
  output cel_pkg::entry_t           push_data,
  input  logic                      full
);

  localparam logic [cel_pkg::LOG_TABLE_DEPTH*cel_pkg::ROM_W-1:0] LOG_ROM =
    cel_pkg::build_log_rom();

  cel_pkg::front_state_t state, state_next;

  logic                          op_r;
  logic [cel_pkg::Q_W-1:0]       p_r;
  logic [cel_pkg::Q_W-1:0]       t_r;
  logic [cel_pkg::NLOG_W-1:0]    nlog_r;
  logic [cel_pkg::NUM_W-1:0]     num_r;

  logic [cel_pkg::Q_W-1:0]       pc;
  logic [4:0]                    lead;
  logic [cel_pkg::Q_W-1:0]       diff;
  logic [cel_pkg::Q_W+cel_pkg::LOG_IDX_W-1:0] shifted;
  logic [cel_pkg::LOG_IDX_W-1:0] idx;
  logic [cel_pkg::ROM_W-1:0]     lval;
  logic [cel_pkg::NLOG_W-1:0]    base;
  logic [cel_pkg::NLOG_W-1:0]    nlog;
  logic [37:0]                   term_full;

  always_comb begin
    if (p_r > cel_pkg::ONE_Q16) pc = cel_pkg::ONE_Q16;
    else if (p_r == '0) pc = cel_pkg::Q_W'(1);
    else pc = p_r;
    lead = '0;
    for (int j = 1; j < cel_pkg::Q_W; j++) begin
      if (pc[j]) lead = 5'(j);
    end
    diff    = pc - (cel_pkg::Q_W'(1) << lead);
    shifted = ({{cel_pkg::LOG_IDX_W{1'b0}}, diff} << cel_pkg::LOG_IDX_W) >> lead;
    idx     = shifted[cel_pkg::LOG_IDX_W-1:0];
    lval    = LOG_ROM[idx*cel_pkg::ROM_W +: cel_pkg::ROM_W];
    base    = cel_pkg::NLOG_W'(5'd16 - lead) * cel_pkg::LN2_Q16;
    nlog    = (base > cel_pkg::NLOG_W'(lval)) ? base - cel_pkg::NLOG_W'(lval) : '0;
  end

  assign term_full = 38'(t_r) * 38'(nlog_r) + 38'(32768);

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    push       = 1'b0;
    unique case (state)
      cel_pkg::F_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) state_next = cel_pkg::F_LOG;
      end
      cel_pkg::F_LOG: state_next = cel_pkg::F_PUSH;
      cel_pkg::F_PUSH: begin
        if (!full) begin
          push       = 1'b1;
          state_next = cel_pkg::F_IDLE;
        end
      end
      default: state_next = cel_pkg::F_IDLE;
    endcase
  end

  assign push_data.operation   = op_r;
  assign push_data.probability = p_r;
  assign push_data.target_nz   = (t_r != '0);
  assign push_data.num         = num_r;
  assign push_data.term        = term_full[16 +: cel_pkg::TERM_W];

  always_ff @(posedge clk) begin
    if (rst) state <= cel_pkg::F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == cel_pkg::F_IDLE && item_valid) begin
      op_r <= item.operation;
      p_r  <= item.probability;
      t_r  <= item.target;
    end
    if (state == cel_pkg::F_LOG) begin
      nlog_r <= nlog;
      num_r  <= cel_pkg::NUM_W'(inverse_batch) * cel_pkg::NUM_W'(t_r);
    end
  end

endmodule

// ----- rtl/cel_queue.sv -----
// ----------------------------------------------------------------------------
// cel_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module cel_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cel_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output cel_pkg::entry_t pop_data
);

  cel_pkg::entry_t mem [cel_pkg::QUEUE_DEPTH];

  logic [cel_pkg::QPTR_W-1:0] wr_ptr;
  logic [cel_pkg::QPTR_W-1:0] rd_ptr;
  logic [cel_pkg::QCNT_W-1:0] count;

  assign full      = (count == cel_pkg::QCNT_W'(cel_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + cel_pkg::QCNT_W'(push) - cel_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- rtl/cel_back.sv -----
// ----------------------------------------------------------------------------
// cel_back
// serial divide for the gradient, sample tracking and score totals
// ----------------------------------------------------------------------------
`include "cross_entropy_loss_scorer_macros.svh"

module cel_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_valid,
  input  cel_pkg::entry_t           pop_data,
  output logic                      pop,
  input  logic [cel_pkg::CLS_W-1:0] class_count,
  output logic                      result_valid,
  input  logic                      result_ready,
  output cel_pkg::result_t          result
);

  cel_pkg::back_state_t state, state_next;

  cel_pkg::entry_t                ent;
  logic [cel_pkg::DVD_W-1:0]      dvd;
  logic [cel_pkg::Q_W-1:0]        rem;
  logic [cel_pkg::DIV_CNT_W-1:0]  cnt;

  logic [cel_pkg::IDX_W-1:0]  element_index;
  logic [cel_pkg::Q_W-1:0]    best_value;
  logic [cel_pkg::IDX_W-1:0]  best_index;
  logic [cel_pkg::IDX_W-1:0]  active_class;
  logic [cel_pkg::LOSS_W-1:0] running_loss;
  logic [cel_pkg::CNT_W-1:0]  correct_count;
  logic [cel_pkg::CNT_W-1:0]  incorrect_count;
  logic [cel_pkg::CUM_W-1:0]  cumulative_loss;

  logic                       commit;
  logic [cel_pkg::Q_W:0]      trial;
  logic                       qbit;
  logic [cel_pkg::CLS_W-1:0]  count_eff;
  logic                       better;
  logic [cel_pkg::IDX_W-1:0]  best_index_next;
  logic [cel_pkg::IDX_W-1:0]  active_next;
  logic [cel_pkg::LOSS_W:0]   loss_sum;
  logic [cel_pkg::LOSS_W-1:0] running_next;
  logic                       done;
  logic                       hit;
  logic [cel_pkg::CUM_W:0]    cum_sum;
  logic [cel_pkg::CUM_W-1:0]  cum_next;
  logic [cel_pkg::CNT_W-1:0]  correct_next;
  logic [cel_pkg::CNT_W-1:0]  incorrect_next;
  logic [cel_pkg::GRAD_W-1:0] mag;

  assign trial = {rem, dvd[cel_pkg::DVD_W-1]};
  assign qbit  = (trial >= {1'b0, ent.probability});

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    commit     = 1'b0;
    unique case (state)
      cel_pkg::B_IDLE: begin
        if (pop_valid) begin
          pop = 1'b1;
          if (pop_data.operation == cel_pkg::OP_CLEAR) state_next = cel_pkg::B_FIN;
          else state_next = cel_pkg::B_DIV;
        end
      end
      cel_pkg::B_DIV: begin
        if (cnt == cel_pkg::DIV_CNT_W'(cel_pkg::DIV_STEPS - 1)) state_next = cel_pkg::B_FIN;
      end
      cel_pkg::B_FIN: begin
        if (!result_valid || result_ready) begin
          commit     = 1'b1;
          state_next = cel_pkg::B_IDLE;
        end
      end
      default: state_next = cel_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    if (class_count == '0) count_eff = cel_pkg::CLS_W'(1);
    else if (class_count > cel_pkg::CLS_W'(cel_pkg::MAX_CLASSES))
      count_eff = cel_pkg::CLS_W'(cel_pkg::MAX_CLASSES);
    else count_eff = class_count;
    better          = (ent.probability > best_value);
    best_index_next = better ? element_index : best_index;
    active_next     = ent.target_nz ? element_index : active_class;
    loss_sum        = {1'b0, running_loss} + (cel_pkg::LOSS_W+1)'(ent.term);
    running_next    = loss_sum[cel_pkg::LOSS_W] ? '1 : loss_sum[cel_pkg::LOSS_W-1:0];
    done            = ({1'b0, element_index} + cel_pkg::CLS_W'(1)) >= count_eff;
    hit             = done && (best_index_next == active_next);
    cum_sum         = {1'b0, cumulative_loss} + (cel_pkg::CUM_W+1)'(running_next);
    if (ent.probability == '0)
      mag = (ent.num == '0) ? '0 : cel_pkg::GRAD_MAG_MAX;
    else mag = cel_pkg::GRAD_W'(dvd);
    cum_next       = cumulative_loss;
    correct_next   = correct_count;
    incorrect_next = incorrect_count;
    if (ent.operation == cel_pkg::OP_CLEAR) begin
      cum_next       = '0;
      correct_next   = '0;
      incorrect_next = '0;
    end else if (done) begin
      cum_next = cum_sum[cel_pkg::CUM_W] ? '1 : cum_sum[cel_pkg::CUM_W-1:0];
      if (hit) begin
        if (correct_count != '1) correct_next = correct_count + 1'b1;
      end else begin
        if (incorrect_count != '1) incorrect_next = incorrect_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cel_pkg::B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == cel_pkg::B_IDLE && pop_valid) begin
      ent <= pop_data;
      dvd <= cel_pkg::DVD_W'(pop_data.num) + cel_pkg::DVD_W'(pop_data.probability >> 1);
      rem <= '0;
      cnt <= '0;
    end
    if (state == cel_pkg::B_DIV) begin
      rem <= qbit ? cel_pkg::Q_W'(trial - {1'b0, ent.probability}) : trial[cel_pkg::Q_W-1:0];
      dvd <= {dvd[cel_pkg::DVD_W-2:0], qbit};
      cnt <= cnt + 1'b1;
    end
    if (commit) begin
      result.correct_total   <= correct_next;
      result.incorrect_total <= incorrect_next;
      result.loss_total      <= cum_next;
      if (ent.operation == cel_pkg::OP_CLEAR) begin
        result.gradient    <= '0;
        result.sample_done <= 1'b0;
        result.sample_loss <= '0;
        result.hit         <= 1'b0;
      end else begin
        result.gradient    <= $signed(-mag);
        result.sample_done <= done;
        result.sample_loss <= done ? running_next : '0;
        result.hit         <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid    <= 1'b0;
      element_index   <= '0;
      best_value      <= '0;
      best_index      <= '0;
      active_class    <= '0;
      running_loss    <= '0;
      correct_count   <= '0;
      incorrect_count <= '0;
      cumulative_loss <= '0;
    end else begin
      if (commit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      if (commit) begin
        correct_count   <= correct_next;
        incorrect_count <= incorrect_next;
        cumulative_loss <= cum_next;
        if (ent.operation == cel_pkg::OP_ELEMENT) begin
          active_class <= active_next;
          if (done) begin
            element_index <= '0;
            best_value    <= '0;
            best_index    <= '0;
            running_loss  <= '0;
          end else begin
            element_index <= element_index + 1'b1;
            running_loss  <= running_next;
            best_index    <= best_index_next;
            if (better) best_value <= ent.probability;
          end
        end
      end
    end
  end

  `CEL_ASSERT(a_pop_idle, !pop || state == cel_pkg::B_IDLE)
  `CEL_ASSERT(a_cnt_range, state != cel_pkg::B_DIV || cnt < cel_pkg::DIV_CNT_W'(cel_pkg::DIV_STEPS))
  `CEL_ASSERT_NEXT(a_done_wrap, commit && ent.operation == cel_pkg::OP_ELEMENT && done, element_index == '0 && running_loss == '0)
  `CEL_ASSERT_NEXT(a_commit_valid, commit, result_valid)

endmodule
